// File: hdl/salc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the set-associative lookup cache.
// No dependencies; every other file of the block imports this package.
package salc_pkg;

   localparam int TOTAL_ENTRIES = 2048;
   localparam int WAYS          = 32;
   localparam int WORD_W        = 64;
   localparam int CMD_W         = 2;
   localparam int FILL_WAY_W    = 5;
   localparam int WAY_W         = $clog2(WAYS);
   localparam int IDX_W         = $clog2(TOTAL_ENTRIES);
   localparam int SET_W         = IDX_W - WAY_W;
   localparam int SETS          = TOTAL_ENTRIES / WAYS;
   localparam int HALF_WAYS     = WAYS / 2;
   localparam int LVL_W         = $clog2(WAY_W + 1);
   localparam int REQ_DATA_W    = 328;
   localparam int RSP_DATA_W    = 264;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP  = 2'd0,
      CMD_FILL    = 2'd1,
      CMD_NEW_GEN = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAG,
      ST_VALUE,
      ST_LRU,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] gen;
      logic [WORD_W-1:0] stamp;
   } tag_entry_type;

   typedef tag_entry_type [WAYS-1:0] tag_row_type;

   typedef struct packed {
      logic [WORD_W-1:0] module_ref;
      logic [WORD_W-1:0] symbol_ref;
      logic [WORD_W-1:0] symbol_offset;
      logic [WORD_W-1:0] relocated_address;
   } value_entry_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [WORD_W-1:0]     address;
      logic [FILL_WAY_W-1:0] fill_way;
      value_entry_type       vals;
   } req_type;

   typedef struct packed {
      logic                en;
      logic [WAYS-1:0]     mask;
      logic [SET_W-1:0]    set;
      tag_entry_type       entry;
   } tag_wr_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic             have_free;
      logic [WAY_W-1:0] free_way;
   } sel_type;

   typedef struct packed {
      logic load;
      logic step;
   } lru_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [WAY_W-1:0] way;
   } lru_status_type;

   function automatic logic [WAYS-1:0] onehot_way(input logic [WAY_W-1:0] w);
      logic [WAYS-1:0] m;
      m = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) == w) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// File: hdl/salc_tag_store.sv
`timescale 1ns / 1ps
// Tag memory: one row per set holding key, generation and use stamp of every way.
// Depends on salc_pkg. Read data is registered; writes are masked per way.
module salc_tag_store import salc_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [SET_W-1:0] rd_set,
   output tag_row_type      rd_row,
   input  tag_wr_type       wr
);

   tag_row_type mem_ff [SETS];
   tag_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int w = 0; w < WAYS; w++) begin
            if (wr.mask[w]) begin
               mem_ff[wr.set][w] <= wr.entry;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem_ff[rd_set];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

// File: hdl/salc_value_store.sv
`timescale 1ns / 1ps
// Value memory: the four stored words of every entry, addressed by set and way.
// Depends on salc_pkg. One write port, one registered read port.
module salc_value_store import salc_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  value_entry_type  wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output value_entry_type  rd_data
);

   value_entry_type mem_ff [TOTAL_ENTRIES];
   value_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/salc_way_select.sv
`timescale 1ns / 1ps
// Way selection over one set row: hit way and last invalid way.
// Depends on salc_pkg. Purely combinational.
module salc_way_select import salc_pkg::*; (
   input  tag_row_type       row,
   input  logic [WORD_W-1:0] key,
   input  logic [WORD_W-1:0] cur_gen,
   output sel_type           sel
);

   logic [WAYS-1:0] valid;
   logic [WAYS-1:0] match;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         valid[w] = (row[w].gen == cur_gen);
         match[w] = valid[w] && (row[w].key == key);
      end
   end

   // The first matching way wins, while the last invalid way is the free one.
   always_comb begin
      sel = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            sel.hit     = 1'b1;
            sel.hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!valid[w]) begin
            sel.have_free = 1'b1;
            sel.free_way  = WAY_W'(w);
         end
      end
   end

endmodule

// File: hdl/salc_lru_tree.sv
`timescale 1ns / 1ps
// Registered minimum tree over the use stamps of one set, one level per cycle.
// Depends on salc_pkg. The lower way wins when two stamps are equal.
module salc_lru_tree import salc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  lru_ctrl_type   ctrl,
   input  tag_row_type    row,
   output lru_status_type status
);

   typedef struct packed {
      logic [WORD_W-1:0] stamp;
      logic [WAY_W-1:0]  way;
   } cand_type;

   cand_type         cand_ff [HALF_WAYS];
   cand_type         cand_in [HALF_WAYS];
   logic [LVL_W-1:0] lvl_ff;
   logic [LVL_W-1:0] lvl_in;

   always_comb begin
      for (int i = 0; i < HALF_WAYS; i++) begin
         cand_in[i] = cand_ff[i];
      end
      if (ctrl.load) begin
         // First level straight from the memory row.
         for (int i = 0; i < HALF_WAYS; i++) begin
            if (row[2*i+1].stamp < row[2*i].stamp) begin
               cand_in[i] = '{stamp: row[2*i+1].stamp, way: WAY_W'(2*i+1)};
            end else begin
               cand_in[i] = '{stamp: row[2*i].stamp, way: WAY_W'(2*i)};
            end
         end
      end else if (ctrl.step && lvl_ff != '0) begin
         for (int i = 0; i < HALF_WAYS / 2; i++) begin
            if (cand_ff[2*i+1].stamp < cand_ff[2*i].stamp) begin
               cand_in[i] = cand_ff[2*i+1];
            end else begin
               cand_in[i] = cand_ff[2*i];
            end
         end
      end
   end

   always_comb begin
      lvl_in = lvl_ff;
      if (ctrl.load) begin
         lvl_in = LVL_W'(WAY_W - 1);
      end else if (ctrl.step && lvl_ff != '0) begin
         lvl_in = lvl_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HALF_WAYS; i++) begin
         cand_ff[i] <= cand_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '0;
      end else begin
         lvl_ff <= lvl_in;
      end
   end

   assign status.done = (lvl_ff == '0);
   assign status.way  = cand_ff[0].way;

endmodule

// File: hdl/set_assoc_lru_lookup_cache_top.sv
`timescale 1ns / 1ps
// Set-associative lookup cache with LRU victim choice; one request in flight at a time.
// Lookup hit: a tag read (ST_TAG) and then a value read (ST_VALUE) come before the registered result.
// Miss with an invalid way answers from ST_TAG; fill and new generation answer from ST_DONE.
// Miss on a full set: the stamp minimum tree in ST_LRU takes one level per cycle before the result.
// Synchronous reset; afterwards a pass over all 64 sets (one set row a cycle) clears the tag memory,
// during which no request is taken.
module set_assoc_lru_lookup_cache_top import salc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // From bit 0: address[64], fill_way[5], module_ref[64], symbol_ref[64],
   // symbol_offset[64], relocated_address[64], zero pad[3].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // From bit 0: command[2].
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0: way[5], out_module_ref[64], out_symbol_ref[64],
   // out_symbol_offset[64], out_relocated_address[64], zero pad[3].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // From bit 0: hit[1].
   output logic [0:0]            rsp_tuser
);

   state_type         state_ff, state_in;
   logic [SET_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [WORD_W-1:0] cur_gen_ff, cur_gen_in;
   logic [WORD_W-1:0] use_clock_ff, use_clock_in;
   logic              rsp_valid_ff, rsp_valid_in;
   req_type           req_ff, req_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [FILL_WAY_W-1:0] rsp_way_ff, rsp_way_in;
   value_entry_type   rsp_vals_ff, rsp_vals_in;

   logic              req_accept;
   logic              out_free;
   logic              finish;
   logic              fill_ok;
   logic              fill_do;
   logic              use_inc;
   logic              gen_inc;
   logic [SET_W-1:0]  req_set;
   logic [WAY_W-1:0]  fill_idx;

   logic              tag_rd_en;
   tag_row_type       tag_rd_row;
   tag_wr_type        tag_wr;
   logic              val_wr_en;
   logic              val_rd_en;
   logic [IDX_W-1:0]  val_rd_idx;
   value_entry_type   val_rd_data;
   sel_type           sel;
   lru_ctrl_type      lru_ctrl;
   lru_status_type    lru_st;

   assign req_in.cmd                    = req_tuser;
   assign req_in.address                = req_tdata[63:0];
   assign req_in.fill_way               = req_tdata[68:64];
   assign req_in.vals.module_ref        = req_tdata[132:69];
   assign req_in.vals.symbol_ref        = req_tdata[196:133];
   assign req_in.vals.symbol_offset     = req_tdata[260:197];
   assign req_in.vals.relocated_address = req_tdata[324:261];

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_set    = req_ff.address[IDX_W-1:WAY_W];
   assign fill_idx   = WAY_W'(req_ff.fill_way);
   assign fill_ok    = (32'(req_ff.fill_way) < WAYS);

   salc_tag_store u_tag_store (
      .clock  (clock),
      .rd_en  (tag_rd_en),
      .rd_set (req_tdata[IDX_W-1:WAY_W]),
      .rd_row (tag_rd_row),
      .wr     (tag_wr)
   );

   salc_value_store u_value_store (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_idx  ({req_set, fill_idx}),
      .wr_data (req_ff.vals),
      .rd_en   (val_rd_en),
      .rd_idx  (val_rd_idx),
      .rd_data (val_rd_data)
   );

   salc_way_select u_way_select (
      .row     (tag_rd_row),
      .key     (req_ff.address),
      .cur_gen (cur_gen_ff),
      .sel     (sel)
   );

   salc_lru_tree u_lru_tree (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lru_ctrl),
      .row    (tag_rd_row),
      .status (lru_st)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == CMD_LOOKUP) begin
                  state_in = ST_TAG;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_TAG: begin
            if (sel.hit) begin
               state_in = ST_VALUE;
            end else if (!sel.have_free) begin
               state_in = ST_LRU;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_VALUE, ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LRU: begin
            if (lru_st.done && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready    = 1'b0;
      tag_rd_en     = 1'b0;
      tag_wr        = '0;
      val_wr_en     = 1'b0;
      val_rd_en     = 1'b0;
      val_rd_idx    = {req_set, sel.hit_way};
      lru_ctrl      = '0;
      finish        = 1'b0;
      fill_do       = 1'b0;
      gen_inc       = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_way_in    = '0;
      rsp_vals_in   = '0;
      case (state_ff)
         ST_CLEAR: begin
            tag_wr.en   = 1'b1;
            tag_wr.mask = '1;
            tag_wr.set  = clr_cnt_ff;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            tag_rd_en  = req_accept;
         end
         ST_TAG: begin
            if (sel.hit) begin
               // Refresh the stamp of the hit way and fetch its values.
               tag_wr.en          = 1'b1;
               tag_wr.mask        = onehot_way(sel.hit_way);
               tag_wr.set         = req_set;
               tag_wr.entry.key   = tag_rd_row[sel.hit_way].key;
               tag_wr.entry.gen   = tag_rd_row[sel.hit_way].gen;
               tag_wr.entry.stamp = use_clock_ff;
               val_rd_en          = 1'b1;
            end else if (!sel.have_free) begin
               lru_ctrl.load = 1'b1;
            end else begin
               finish     = out_free;
               rsp_way_in = FILL_WAY_W'(sel.free_way);
            end
         end
         ST_VALUE: begin
            finish      = out_free;
            rsp_hit_in  = 1'b1;
            rsp_way_in  = FILL_WAY_W'(hit_way_ff);
            rsp_vals_in = val_rd_data;
         end
         ST_LRU: begin
            lru_ctrl.step = 1'b1;
            finish        = lru_st.done && out_free;
            rsp_way_in    = FILL_WAY_W'(lru_st.way);
         end
         ST_DONE: begin
            finish = out_free;
            case (req_ff.cmd)
               CMD_FILL: begin
                  rsp_way_in = req_ff.fill_way;
                  fill_do    = out_free && fill_ok;
               end
               CMD_NEW_GEN: begin
                  gen_inc = out_free;
               end
               default: begin
                  rsp_way_in = '0;
               end
            endcase
            if (fill_do) begin
               tag_wr.en          = 1'b1;
               tag_wr.mask        = onehot_way(fill_idx);
               tag_wr.set         = req_set;
               tag_wr.entry.key   = req_ff.address;
               tag_wr.entry.gen   = cur_gen_ff;
               tag_wr.entry.stamp = use_clock_ff;
               val_wr_en          = 1'b1;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   assign use_inc = ((state_ff == ST_TAG) && sel.hit) || fill_do;

   always_comb begin
      clr_cnt_in   = (state_ff == ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      cur_gen_in   = gen_inc ? cur_gen_ff + 64'd1 : cur_gen_ff;
      use_clock_in = use_inc ? use_clock_ff + 64'd1 : use_clock_ff;
      rsp_valid_in = finish || (rsp_valid_ff && !rsp_tready);
      hit_way_in   = sel.hit_way;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cur_gen_ff   <= 64'd1;
         use_clock_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cur_gen_ff   <= cur_gen_in;
         use_clock_ff <= use_clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_in;
      end
      if (state_ff == ST_TAG) begin
         hit_way_ff <= hit_way_in;
      end
      if (finish) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_way_ff  <= rsp_way_in;
         rsp_vals_ff <= rsp_vals_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_hit_ff;
   assign rsp_tdata    = {3'b000,
                          rsp_vals_ff.relocated_address,
                          rsp_vals_ff.symbol_offset,
                          rsp_vals_ff.symbol_ref,
                          rsp_vals_ff.module_ref,
                          rsp_way_ff};

`ifndef SYNTHESIS
   a_tag_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(tag_wr.en && tag_rd_en))
      else $error("tag memory read and write in the same cycle");

   a_value_write_fill_only: assert property (@(posedge clock) disable iff (reset)
      val_wr_en |-> (state_ff == ST_DONE) && (req_ff.cmd == CMD_FILL))
      else $error("value memory written outside a fill");

   a_use_clock_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (use_clock_ff == $past(use_clock_ff)) ||
               (use_clock_ff == $past(use_clock_ff) + 64'd1))
      else $error("use clock moved by more than one");

   a_value_after_tag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VALUE) |-> ($past(state_ff) == ST_TAG) || ($past(state_ff) == ST_VALUE))
      else $error("value read state entered without a tag hit");
`endif

endmodule
